FILE: rtl/rppg_pkg.sv
// Shared types and constants of the reference pulse profile generator.
`timescale 1ns / 1ps

package rppg_pkg;

    // Fixed-point widths.
    localparam int LVL_W  = 32;   // Q16.16 level and slope
    localparam int RATE_W = 31;   // Q15.16 unsigned rates and times
    localparam int DT_W   = 24;   // Q0.24 tick duration
    localparam int ADDR_W = 5;    // byte address of the register file

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_AMPLITUDE   = 3'd0,
        REG_RAMP_RATE   = 3'd1,
        REG_PEAK_DWELL  = 3'd2,
        REG_ZERO_PAUSE  = 3'd3,
        REG_ACCEL_LIMIT = 3'd4,
        REG_REPEAT_MODE = 3'd5
    } t_reg_idx;

    // Input commands; the fourth code is ignored.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd;

    // Generator phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RAMP  = 2'd1,
        PH_DWELL = 2'd2
    } t_phase;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_STOP,
        OP_IDLE_TICK,
        OP_DWELL,
        OP_STEP,
        OP_LIN_MUL,
        OP_LIN_DONE,
        OP_DV_MUL,
        OP_RAD_LO,
        OP_RAD_HI,
        OP_SQRT_INIT,
        OP_SQRT_ITER,
        OP_SLOPE,
        OP_POS_MUL
    } t_op;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LIN_DONE,
        ST_RAD_LO,
        ST_RAD_HI,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SLOPE,
        ST_POS_MUL,
        ST_TRAP_DONE,
        ST_OUT
    } t_state;

    // Configuration register contents.
    typedef struct packed {
        logic signed [LVL_W-1:0] amplitude;
        logic [RATE_W-1:0]       ramp_rate;
        logic [RATE_W-1:0]       peak_dwell;
        logic [RATE_W-1:0]       zero_pause;
        logic [RATE_W-1:0]       accel_limit;
        logic                    repeat_mode;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        t_op  op;
        logic trap_done;   // finish a trapezoidal step
        logic publish;     // copy the state into the result register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] cmd;
        t_phase     phase;
        logic       rate_zero;
        logic       accel_zero;
    } t_dp_status;

endpackage

FILE: rtl/rppg_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module rppg_regs
    import rppg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; addresses past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_AMPLITUDE:   r_cfg.amplitude   <= pwdata;
                REG_RAMP_RATE:   r_cfg.ramp_rate   <= pwdata[RATE_W-1:0];
                REG_PEAK_DWELL:  r_cfg.peak_dwell  <= pwdata[RATE_W-1:0];
                REG_ZERO_PAUSE:  r_cfg.zero_pause  <= pwdata[RATE_W-1:0];
                REG_ACCEL_LIMIT: r_cfg.accel_limit <= pwdata[RATE_W-1:0];
                REG_REPEAT_MODE: r_cfg.repeat_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        unique case (w_idx)
            REG_AMPLITUDE:   prdata = r_cfg.amplitude;
            REG_RAMP_RATE:   prdata = {1'b0, r_cfg.ramp_rate};
            REG_PEAK_DWELL:  prdata = {1'b0, r_cfg.peak_dwell};
            REG_ZERO_PAUSE:  prdata = {1'b0, r_cfg.zero_pause};
            REG_ACCEL_LIMIT: prdata = {1'b0, r_cfg.accel_limit};
            REG_REPEAT_MODE: prdata = {31'd0, r_cfg.repeat_mode};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/rppg_ctrl.sv
// Controller state machine that sequences the profile datapath.
`timescale 1ns / 1ps

module rppg_ctrl
    import rppg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_valid, n_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid & ~i_out_ready;
        o_cmd   = '{op: OP_NONE, trap_done: 1'b0, publish: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_OUT;
                priority case (i_status.cmd)
                    CMD_START: o_cmd.op = OP_START;
                    CMD_STOP:  o_cmd.op = OP_STOP;
                    CMD_TICK: begin
                        priority case (i_status.phase)
                            PH_DWELL: o_cmd.op = OP_DWELL;
                            PH_RAMP: begin
                                if (i_status.rate_zero) begin
                                    o_cmd.op = OP_STEP;
                                end else if (i_status.accel_zero) begin
                                    o_cmd.op = OP_LIN_MUL;
                                    n_state  = ST_LIN_DONE;
                                end else begin
                                    o_cmd.op = OP_DV_MUL;
                                    n_state  = ST_RAD_LO;
                                end
                            end
                            default: o_cmd.op = OP_IDLE_TICK;
                        endcase
                    end
                    default: o_cmd.op = OP_NONE;
                endcase
            end
            ST_LIN_DONE: begin
                o_cmd.op = OP_LIN_DONE;
                n_state  = ST_OUT;
            end
            ST_RAD_LO: begin
                o_cmd.op = OP_RAD_LO;
                n_state  = ST_RAD_HI;
            end
            ST_RAD_HI: begin
                o_cmd.op = OP_RAD_HI;
                n_state  = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                o_cmd.op = OP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT_ITER;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                o_cmd.op = OP_SLOPE;
                n_state  = ST_POS_MUL;
            end
            ST_POS_MUL: begin
                o_cmd.op = OP_POS_MUL;
                n_state  = ST_TRAP_DONE;
            end
            ST_TRAP_DONE: begin
                o_cmd.trap_done = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the result register is free.
                if (!r_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_valid       = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/rppg_dp.sv
// Datapath: profile state, shared multiplier, square-root unit and result register.
`timescale 1ns / 1ps

module rppg_dp
    import rppg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic [1:0]              i_in_cmd,
    input  logic [DT_W-1:0]         i_in_elapsed,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    output logic signed [LVL_W-1:0] o_level,
    output logic signed [LVL_W-1:0] o_slope,
    output logic                    o_busy
);

    localparam logic signed [LVL_W-1:0] LvlMax = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] LvlMin = {1'b1, {(LVL_W-1){1'b0}}};

    // Saturate a 34-bit signed value to the level width.
    function automatic logic signed [LVL_W-1:0] sat34(input logic signed [33:0] x);
        logic signed [33:0] hi_lim;
        logic signed [33:0] lo_lim;
        hi_lim = 34'(LvlMax);
        lo_lim = 34'(LvlMin);
        if (x > hi_lim) begin
            return LvlMax;
        end else if (x < lo_lim) begin
            return LvlMin;
        end
        return x[LVL_W-1:0];
    endfunction

    // Profile state.
    logic [1:0]              r_cmd, n_cmd;
    logic [DT_W-1:0]         r_dt, n_dt;
    t_phase                  r_phase, n_phase;
    logic signed [LVL_W-1:0] r_level, n_level;
    logic signed [LVL_W-1:0] r_slope, n_slope;
    logic signed [LVL_W-1:0] r_target, n_target;
    logic signed [LVL_W-1:0] r_peak, n_peak;
    logic                    r_heading, n_heading;
    logic                    r_repeat, n_repeat;
    logic [31:0]             r_hold, n_hold;

    // Working registers.
    logic signed [57:0]      r_prod, n_prod;
    logic [31:0]             r_dv, n_dv;
    logic [32:0]             r_dist, n_dist;
    logic                    r_dir_neg, n_dir_neg;
    logic [47:0]             r_rad_lo, n_rad_lo;
    logic [63:0]             r_rem, n_rem;
    logic [63:0]             r_res, n_res;
    logic [63:0]             r_bit, n_bit;
    logic signed [LVL_W-1:0] r_o_level, r_o_slope;
    logic                    r_o_busy;

    // Shared multiplier operands.
    logic signed [32:0]      w_mul_a;
    logic [DT_W-1:0]         w_mul_b;
    logic signed [57:0]      w_prod;

    // Scratch values.
    logic                    w_done;
    logic signed [33:0]      w_lv;
    logic signed [32:0]      w_to_go;
    logic [64:0]             w_sum;
    logic [63:0]             w_trial;
    logic [31:0]             w_cruise;
    logic signed [33:0]      w_want, w_lo, w_hi;
    logic [32:0]             w_hold;
    logic [31:0]             w_lim;
    logic signed [LVL_W-1:0] w_sat;
    logic                    w_past;

    assign w_prod = 58'(w_mul_a) * $signed({1'b0, w_mul_b});

    assign o_status = '{cmd: r_cmd, phase: r_phase,
                        rate_zero: (i_cfg.ramp_rate == '0),
                        accel_zero: (i_cfg.accel_limit == '0)};
    assign o_level  = r_o_level;
    assign o_slope  = r_o_slope;
    assign o_busy   = r_o_busy;

    // Profile state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_level   <= '0;
            r_slope   <= '0;
            r_target  <= '0;
            r_peak    <= '0;
            r_heading <= 1'b0;
            r_repeat  <= 1'b0;
            r_hold    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_slope   <= n_slope;
            r_target  <= n_target;
            r_peak    <= n_peak;
            r_heading <= n_heading;
            r_repeat  <= n_repeat;
            r_hold    <= n_hold;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_dt      <= n_dt;
        r_prod    <= n_prod;
        r_dv      <= n_dv;
        r_dist    <= n_dist;
        r_dir_neg <= n_dir_neg;
        r_rad_lo  <= n_rad_lo;
        r_rem     <= n_rem;
        r_res     <= n_res;
        r_bit     <= n_bit;
        if (i_cmd.publish) begin
            r_o_level <= r_level;
            r_o_slope <= r_slope;
            r_o_busy  <= (r_phase == PH_RAMP) || (r_phase == PH_DWELL);
        end
    end

    // Operation decode.
    always_comb begin
        n_cmd     = r_cmd;
        n_dt      = r_dt;
        n_phase   = r_phase;
        n_level   = r_level;
        n_slope   = r_slope;
        n_target  = r_target;
        n_peak    = r_peak;
        n_heading = r_heading;
        n_repeat  = r_repeat;
        n_hold    = r_hold;
        n_prod    = r_prod;
        n_dv      = r_dv;
        n_dist    = r_dist;
        n_dir_neg = r_dir_neg;
        n_rad_lo  = r_rad_lo;
        n_rem     = r_rem;
        n_res     = r_res;
        n_bit     = r_bit;
        w_mul_a   = 33'({2'b00, i_cfg.ramp_rate});
        w_mul_b   = r_dt;
        w_done    = 1'b0;
        w_lv      = '0;
        w_to_go   = 33'(r_target) - 33'(r_level);
        w_sum     = 65'(r_rad_lo) + {1'b0, r_prod[47:0], 16'd0};
        w_trial   = r_res + r_bit;
        w_cruise  = ({1'b0, i_cfg.ramp_rate} < r_res[31:0]) ?
                    {1'b0, i_cfg.ramp_rate} : r_res[31:0];
        w_want    = r_dir_neg ? -34'(w_cruise) : 34'(w_cruise);
        w_lo      = 34'(r_slope) - 34'(r_dv);
        w_hi      = 34'(r_slope) + 34'(r_dv);
        w_hold    = 33'(r_hold) + 33'(((25'(r_dt) + 25'd128) >> 8));
        w_lim     = r_heading ? {1'b0, i_cfg.peak_dwell} : {1'b0, i_cfg.zero_pause};
        w_sat     = sat34(34'(r_level) + 34'($signed(r_prod[55:24])));
        w_past    = r_dir_neg ? (w_sat <= r_target) : (w_sat >= r_target);

        unique case (i_cmd.op)
            OP_LOAD: begin
                n_cmd = i_in_cmd;
                n_dt  = i_in_elapsed;
            end
            OP_START: begin
                n_peak    = i_cfg.amplitude;
                n_target  = i_cfg.amplitude;
                n_heading = 1'b1;
                n_repeat  = i_cfg.repeat_mode;
                n_level   = '0;
                n_slope   = '0;
                n_hold    = '0;
                n_phase   = PH_RAMP;
            end
            OP_STOP: begin
                n_repeat  = 1'b0;
                n_target  = '0;
                n_heading = 1'b0;
                n_phase   = (r_level == '0) ? PH_IDLE : PH_RAMP;
            end
            OP_IDLE_TICK: begin
                n_phase = PH_IDLE;
                n_level = '0;
                n_slope = '0;
            end
            OP_DWELL: begin
                n_level = r_target;
                n_slope = '0;
                n_hold  = w_hold[32] ? 32'hFFFF_FFFF : w_hold[31:0];
                if (n_hold >= w_lim) begin
                    if (r_heading) begin
                        n_target  = '0;
                        n_heading = 1'b0;
                    end else begin
                        // Negating the most negative peak saturates to the maximum.
                        n_peak    = (r_peak == LvlMin) ? LvlMax : -r_peak;
                        n_target  = n_peak;
                        n_heading = 1'b1;
                    end
                    n_phase = PH_RAMP;
                end
            end
            OP_STEP: begin
                n_level = r_target;
                n_slope = '0;
                w_done  = 1'b1;
            end
            OP_LIN_MUL: begin
                n_prod = w_prod;
            end
            OP_LIN_DONE: begin
                n_slope = (r_target > r_level) ? 32'({1'b0, i_cfg.ramp_rate}) :
                          -32'({1'b0, i_cfg.ramp_rate});
                if (r_level < r_target) begin
                    w_lv = 34'(r_level) + 34'({1'b0, r_prod[54:24]});
                    w_done = (w_lv >= 34'(r_target));
                end else begin
                    w_lv = 34'(r_level) - 34'({1'b0, r_prod[54:24]});
                    w_done = (w_lv <= 34'(r_target));
                end
                n_level = w_done ? r_target : w_lv[LVL_W-1:0];
            end
            OP_DV_MUL: begin
                w_mul_a   = 33'({2'b00, i_cfg.accel_limit});
                n_prod    = w_prod;
                n_dir_neg = w_to_go[32];
                n_dist    = w_to_go[32] ? 33'(-w_to_go) : 33'(w_to_go);
            end
            OP_RAD_LO: begin
                n_dv      = {1'b0, r_prod[54:24]};
                w_mul_a   = 33'({2'b00, i_cfg.accel_limit});
                w_mul_b   = {8'd0, r_dist[15:0]};
                n_prod    = w_prod;
            end
            OP_RAD_HI: begin
                n_rad_lo  = r_prod[47:0];
                w_mul_a   = 33'({2'b00, i_cfg.accel_limit});
                w_mul_b   = {7'd0, r_dist[32:16]};
                n_prod    = w_prod;
            end
            OP_SQRT_INIT: begin
                // Radicand is twice the product, saturated at all ones.
                n_rem = w_sum[63] ? 64'hFFFF_FFFF_FFFF_FFFF : {w_sum[62:0], 1'b0};
                n_res = '0;
                n_bit = 64'h4000_0000_0000_0000;
            end
            OP_SQRT_ITER: begin
                if (r_rem >= w_trial) begin
                    n_rem = r_rem - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
            end
            OP_SLOPE: begin
                if (w_want < w_lo) begin
                    n_slope = sat34(w_lo);
                end else if (w_want > w_hi) begin
                    n_slope = sat34(w_hi);
                end else begin
                    n_slope = sat34(w_want);
                end
            end
            OP_POS_MUL: begin
                w_mul_a = 33'(r_slope);
                n_prod  = w_prod;
            end
            default: ;
        endcase

        // Close a trapezoidal step: snap to the target once reached or passed.
        if (i_cmd.trap_done) begin
            n_level = w_past ? r_target : w_sat;
            w_done  = w_past && (r_slope == '0);
        end

        // End of a ramp.
        if (w_done) begin
            if (r_heading || r_repeat) begin
                n_phase = PH_DWELL;
                n_hold  = '0;
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

endmodule

FILE: rtl/reference_pulse_profile_generator.sv
// Top level of the reference pulse profile generator.
// Start, stop, dwell, idle and step items pass from decode to the output state; a linear
// ramp tick adds a finish state, a trapezoidal one the radicand, square-root, slope,
// position and finish states. Throughput: one item at a time; the next item is taken once a
// result is registered. The trapezoidal square-root iteration runs 32 steps.
// Reset is synchronous and active low; it clears the configuration, controller and profile
// state at once, with no clearing pass; the payload and result registers are not reset.
`timescale 1ns / 1ps

module reference_pulse_profile_generator
    import rppg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // elapsed[23:0]
    input  logic [1:0]        s_axis_tuser,   // command[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // level[31:0], slope[63:32]
    output logic              m_axis_tuser,   // busy_res[0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg                    w_cfg;
    t_dp_cmd                 w_cmd;
    t_dp_status              w_status;
    logic signed [LVL_W-1:0] w_level, w_slope;
    logic                    w_busy;

    rppg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rppg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rppg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_cmd     (s_axis_tuser),
        .i_in_elapsed (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_level      (w_level),
        .o_slope      (w_slope),
        .o_busy       (w_busy)
    );

    assign m_axis_tdata = {w_slope, w_level};
    assign m_axis_tuser = w_busy;

endmodule

FILE: rtl/rppg_checker.sv
// Port-level checks of the generator, bound to the top level.
`timescale 1ns / 1ps

module rppg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [1:0] r_pending, n_pending;
    logic       w_in_xfer, w_out_xfer;

    assign w_in_xfer  = s_axis_tvalid & s_axis_tready;
    assign w_out_xfer = m_axis_tvalid & m_axis_tready;

    // Items taken but whose result has not been transferred yet.
    always_comb begin
        n_pending = r_pending;
        if (w_in_xfer && !w_out_xfer) begin
            n_pending = r_pending + 2'd1;
        end else if (!w_in_xfer && w_out_xfer) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Every offered result belongs to an accepted item.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 2'd0)
        else $error("result without an item");

    // At most one item in work besides a waiting result.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many items in flight");

endmodule

bind reference_pulse_profile_generator rppg_checker u_rppg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the reference pulse profile generator.
`timescale 1ns / 1ps

module tb_top;
    import rppg_pkg::*;

    localparam longint LVL_MAX = 64'sd2147483647;
    localparam longint LVL_MIN = -64'sd2147483648;
    localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] dt;
    } t_item;

    typedef struct packed {
        logic [31:0] level;
        logic [31:0] slope;
        logic        busy;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Generator copy: configuration and profile state.
    longint          amp_cfg;
    longint unsigned rate_cfg, dwell_cfg, pause_cfg, accel_cfg;
    logic            repeat_cfg;
    t_phase          gen_phase;
    longint          gen_level, gen_slope, gen_target, gen_peak;
    logic            gen_up, gen_repeat;
    longint unsigned gen_hold;

    t_item   pending_items[$];
    t_sample predicted_outputs[$];
    int      errors;
    int      results_seen;
    int      cycles;
    int      hold_left;
    logic    hold_done;

    reference_pulse_profile_generator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sat_level(longint x);
        return (x > LVL_MAX) ? LVL_MAX : ((x < LVL_MIN) ? LVL_MIN : x);
    endfunction

    // floor(a * b / 2^24) with the low 24 bits of a handled unsigned.
    function automatic longint scale_q24(longint a, longint unsigned b);
        longint unsigned lo;
        longint hi;
        lo = longint'(a) & 64'hFF_FFFF;
        hi = (a - longint'(lo)) >>> 24;
        return hi * longint'(b) + longint'((lo * b) >> 24);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // One trapezoidal tick; returns 1 once settled on the target.
    function automatic bit trap_tick(longint unsigned dt);
        longint to_go, dir, dv, cruise, want, lo, hi;
        longint unsigned dist_v, a2, rad, vb;
        to_go = gen_target - gen_level;
        dir = (to_go >= 0) ? 1 : -1;
        dist_v = (to_go >= 0) ? longint'(to_go) : longint'(-to_go);
        dv = longint'((accel_cfg * dt) >> 24);
        a2 = 2 * accel_cfg;
        rad = (dist_v != 0 && a2 > U64_MAX / dist_v) ? U64_MAX : a2 * dist_v;
        vb = int_sqrt(rad);
        cruise = (rate_cfg < vb) ? longint'(rate_cfg) : longint'(vb);
        want = dir * cruise;
        lo = gen_slope - dv;
        hi = gen_slope + dv;
        gen_slope = sat_level(want < lo ? lo : (want > hi ? hi : want));
        gen_level = sat_level(gen_level + scale_q24(gen_slope, dt));
        if ((gen_target - gen_level) * dir <= 0) begin
            gen_level = gen_target;
            if (gen_slope == 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // One linear tick; returns 1 once the target is reached.
    function automatic bit linear_tick(longint unsigned dt);
        longint stp;
        stp = longint'((rate_cfg * dt) >> 24);
        gen_slope = (gen_target > gen_level) ? longint'(rate_cfg) : -longint'(rate_cfg);
        if (gen_level < gen_target) begin
            gen_level = gen_level + stp;
            if (gen_level >= gen_target) begin
                gen_level = gen_target;
                return 1'b1;
            end
        end else begin
            gen_level = gen_level - stp;
            if (gen_level <= gen_target) begin
                gen_level = gen_target;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advances the generator copy by one command and returns its outputs.
    function automatic t_sample compute_profile_step(t_item it);
        t_sample r;
        bit done;
        longint unsigned h, lim;
        if (it.cmd == CMD_TICK) begin
            if (gen_phase == PH_RAMP) begin
                if (rate_cfg == 0) begin
                    gen_level = gen_target;
                    gen_slope = 0;
                    done = 1'b1;
                end else if (accel_cfg != 0) begin
                    done = trap_tick(it.dt);
                end else begin
                    done = linear_tick(it.dt);
                end
                if (done) begin
                    if (gen_up || gen_repeat) begin
                        gen_phase = PH_DWELL;
                        gen_hold = 0;
                    end else begin
                        gen_phase = PH_IDLE;
                    end
                end
            end else if (gen_phase == PH_DWELL) begin
                h = gen_hold + ((longint'(it.dt) + 128) >> 8);
                lim = gen_up ? dwell_cfg : pause_cfg;
                gen_level = gen_target;
                gen_slope = 0;
                gen_hold = (h > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : h;
                if (gen_hold >= lim) begin
                    if (gen_up) begin
                        gen_target = 0;
                        gen_up = 1'b0;
                    end else begin
                        gen_peak = sat_level(-gen_peak);
                        gen_target = gen_peak;
                        gen_up = 1'b1;
                    end
                    gen_phase = PH_RAMP;
                end
            end else begin
                gen_phase = PH_IDLE;
                gen_level = 0;
                gen_slope = 0;
            end
        end else if (it.cmd == CMD_START) begin
            gen_peak = sat_level(amp_cfg);
            gen_target = gen_peak;
            gen_up = 1'b1;
            gen_repeat = repeat_cfg;
            gen_level = 0;
            gen_slope = 0;
            gen_hold = 0;
            gen_phase = PH_RAMP;
        end else if (it.cmd == CMD_STOP) begin
            gen_repeat = 1'b0;
            gen_target = 0;
            gen_up = 1'b0;
            gen_phase = (gen_level == 0) ? PH_IDLE : PH_RAMP;
        end
        r.level = gen_level[31:0];
        r.slope = gen_slope[31:0];
        r.busy = (gen_phase == PH_RAMP || gen_phase == PH_DWELL);
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 field, results_seen, got, want);
        errors++;
    endtask

    // Driver: bursts of transfers separated by random gaps.
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        t_item nxt;
        logic  offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_outputs.push_back(
                    compute_profile_step(t_item'({s_axis_tuser, s_axis_tdata})));
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    s_axis_tdata <= nxt.dt;
                    s_axis_tuser <= nxt.cmd;
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // One long receiver hold-off once the run is well under way and items are queued.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= 150 && pending_items.size() > 4) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compares every result transfer and stalls on its own pattern.
    int stall_phase;
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_outputs.size() == 0) begin
                    report("unexpected result", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (m_axis_tdata[31:0] !== want.level)
                        report("level", m_axis_tdata[31:0], want.level);
                    if (m_axis_tdata[63:32] !== want.slope)
                        report("slope", m_axis_tdata[63:32], want.slope);
                    if (m_axis_tuser !== want.busy)
                        report("busy_res", {31'd0, m_axis_tuser}, {31'd0, want.busy});
                end
                results_seen <= results_seen + 1;
            end
            stall_phase <= (stall_phase + 1) % 192;
            m_axis_tready <= (hold_left == 0) &&
                             (stall_phase < 64 || $urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AMPLITUDE:   amp_cfg = longint'(signed'(value));
            REG_RAMP_RATE:   rate_cfg = value[30:0];
            REG_PEAK_DWELL:  dwell_cfg = value[30:0];
            REG_ZERO_PAUSE:  pause_cfg = value[30:0];
            REG_ACCEL_LIMIT: accel_cfg = value[30:0];
            REG_REPEAT_MODE: repeat_cfg = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] amp, logic [31:0] rate, logic [31:0] dwell,
                             logic [31:0] pause, logic [31:0] accel, logic rep);
        reg_write(REG_AMPLITUDE, amp);
        reg_write(REG_RAMP_RATE, rate);
        reg_write(REG_PEAK_DWELL, dwell);
        reg_write(REG_ZERO_PAUSE, pause);
        reg_write(REG_ACCEL_LIMIT, accel);
        reg_write(REG_REPEAT_MODE, {31'd0, rep});
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0);
    endtask

    task automatic add_item(t_cmd cmd, logic [23:0] dt);
        pending_items.push_back('{cmd: cmd, dt: dt});
    endtask

    // Random tick lengths: mostly a few milliseconds, now and then any value.
    function automatic logic [23:0] pick_dt();
        return ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3_0000));
    endfunction

    initial begin
        int n;
        logic [31:0] amp;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        amp_cfg = 0;
        rate_cfg = 0;
        dwell_cfg = 0;
        pause_cfg = 0;
        accel_cfg = 0;
        repeat_cfg = 1'b0;
        gen_phase = PH_IDLE;
        gen_level = 0;
        gen_slope = 0;
        gen_target = 0;
        gen_peak = 0;
        gen_up = 1'b0;
        gen_repeat = 1'b0;
        gen_hold = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, ignored code, steps to the negative extreme.
        add_item(CMD_TICK, 24'hFF_FFFF);
        add_item(t_cmd'(2'd3), 24'hFF_FFFF);
        add_item(CMD_STOP, 24'd0);
        wait_drained();
        configure(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_item(CMD_START, 24'd0);
        repeat (5) add_item(CMD_TICK, 24'd0);
        add_item(CMD_STOP, 24'd0);
        add_item(CMD_TICK, 24'd0);
        add_item(CMD_TICK, 24'd0);
        wait_drained();

        // Directed: largest rates and times with the positive extreme.
        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b1);
        add_item(CMD_START, 24'd0);
        repeat (4) add_item(CMD_TICK, 24'hFF_FFFF);
        add_item(CMD_STOP, 24'd0);
        repeat (3) add_item(CMD_TICK, 24'hFF_FFFF);
        wait_drained();

        // Directed: zero-height pulse with a short linear ramp.
        configure(32'd0, 32'h0010_0000, 32'd100, 32'd0, 32'd0, 1'b0);
        add_item(CMD_START, 24'd0);
        repeat (3) add_item(CMD_TICK, 24'h00_8000);
        wait_drained();

        // Random phases with fresh register settings each time.
        n = 0;
        while (n < 650) begin
            amp = 32'($urandom_range(0, 32'h0014_0000));
            if ($urandom_range(0, 1)) amp = -amp;
            if ($urandom_range(0, 15) == 0) amp = $urandom;
            configure(amp,
                      ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 32'h00C8_0000),
                      $urandom_range(0, 4000), $urandom_range(0, 4000),
                      ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 32'h07D0_0000),
                      1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
                reg_write(REG_RAMP_RATE, $urandom);
            add_item(CMD_START, 24'($urandom));
            repeat ($urandom_range(20, 60)) begin
                case ($urandom_range(0, 49))
                    0, 1:    add_item(CMD_STOP, 24'($urandom));
                    2:       add_item(t_cmd'(2'd3), 24'($urandom));
                    3:       add_item(CMD_START, 24'($urandom));
                    default: add_item(CMD_TICK, pick_dt());
                endcase
                n++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_outputs.size() != 0)
            report("missing results", 32'(predicted_outputs.size()), 32'd0);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
